// ----- rtl/core/angle_bias_kalman_filter_core_defines.svh -----
// Assertion macros shared by the angle and bias Kalman filter RTL.
// Included by the files that carry assertions; depends on nothing else.
`ifndef ANGLE_BIAS_KALMAN_FILTER_CORE_DEFINES_SVH
`define ANGLE_BIAS_KALMAN_FILTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ABKF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ABKF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ABKF_ASSERT_SAME(lbl, ante, cons)
`define ABKF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/abkf_pkg.sv -----
// Shared constants and helpers for the angle and bias Kalman filter.
// Used by every module of the block; depends on nothing.
package abkf_pkg;

    localparam int FracBits = 24;
    localparam logic [30:0] QAngleReset = 31'd167772;
    localparam logic [30:0] QGyroReset = 31'd838861;
    localparam logic [30:0] RAngleReset = 31'd8388608;
    localparam logic [30:0] PeriodReset = 31'd167772;
    localparam logic signed [31:0] CovOne = 32'sd16777216;

    localparam logic [2:0] REG_Q_ANGLE = 3'd0;
    localparam logic [2:0] REG_Q_GYRO = 3'd1;
    localparam logic [2:0] REG_R_ANGLE = 3'd2;
    localparam logic [2:0] REG_PERIOD = 3'd3;

    function automatic logic signed [31:0] sat32(input logic signed [44:0] x);
        logic signed [31:0] r;
        if (x > 45'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < -45'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/angle_bias_kalman_filter_core.sv -----
// Top level of the two-state angle and gyro bias Kalman filter.
// Depends on abkf_pkg, abkf_mul, abkf_div and the assertion header.
//
// Usage: a request on the input channel (in_valid, in_ready) carries one
// accelerometer angle and one gyro rate, both signed Q16.16. The block then
// runs one filter step and offers the fused angle and the bias-corrected
// rate on the output channel (out_valid, out_ready). Tuning registers are
// written through the cfg channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and indexes above three are ignored.
// The result is offered when its step is done, and no new request is taken
// until that result has been loaded into the output register: ten products on
// a bit-serial multiplier and two gains on a restoring divider run one after
// another, after the request is taken and before the output is loaded.
// When the innovation variance is not positive the divider is skipped and
// the step is shorter.
// Reset loads the default tuning values, clears the angle and bias and sets
// the covariance to the identity. A stalled receiver holds the result in
// the output register; the next sample is still taken, but its result waits
// until the previous one has gone.
`include "angle_bias_kalman_filter_core_defines.svh"
module angle_bias_kalman_filter_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] angle_meas,
    input  logic signed [31:0] gyro_rate,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] angle_est,
    output logic signed [31:0] rate_est,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data
);
    import abkf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL = 3'd1;
    localparam logic [2:0] S_MWAIT = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_DWAIT = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    localparam logic [3:0] OP_PREDICT = 4'd0;
    localparam logic [3:0] OP_PROP_00 = 4'd1;
    localparam logic [3:0] OP_PROP_X1 = 4'd2;
    localparam logic [3:0] OP_PROP_11 = 4'd3;
    localparam logic [3:0] OP_UPD_00 = 4'd4;
    localparam logic [3:0] OP_UPD_01 = 4'd5;
    localparam logic [3:0] OP_UPD_10 = 4'd6;
    localparam logic [3:0] OP_UPD_11 = 4'd7;
    localparam logic [3:0] OP_CORR_BIAS = 4'd8;
    localparam logic [3:0] OP_CORR_ANGLE = 4'd9;

    logic [2:0]  state_reg;
    logic [3:0]  op_reg;
    logic        sel_reg;
    logic [30:0] q_angle_reg, q_gyro_reg, r_angle_reg, period_reg;
    logic signed [31:0] angle_reg, bias_reg, c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [31:0] k0_reg, k1_reg, t0_reg, t1_reg, meas_reg, gyro_reg;
    logic        out_valid_reg;
    logic signed [31:0] angle_out_reg, rate_out_reg;

    logic               mul_start, mul_done, div_start, div_done;
    logic signed [33:0] mul_a, mul_b;
    logic signed [43:0] mul_res;
    logic signed [31:0] div_num, div_quot;
    logic signed [33:0] e_val;
    logic               e_pos;
    logic signed [31:0] pd0;
    logic signed [33:0] dt_op;

    abkf_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .result(mul_res)
    );

    abkf_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(e_val[32:0]), .done(div_done), .quot(div_quot)
    );

    always_comb
    begin
        dt_op = $signed({3'b000, period_reg});
        pd0 = sat32(45'sd0 + $signed({14'd0, q_angle_reg}) - c01_reg - c10_reg);
        e_val = $signed({3'b000, r_angle_reg}) + c00_reg;
        e_pos = !e_val[33] && (e_val != 34'sd0);
        div_num = sel_reg ? c10_reg : c00_reg;
        mul_a = 34'sd0;
        mul_b = dt_op;
        unique case (op_reg)
            OP_PREDICT: mul_a = 34'(gyro_reg) - 34'(bias_reg);
            OP_PROP_00: mul_a = 34'(pd0);
            OP_PROP_X1: mul_a = 34'(c11_reg);
            OP_PROP_11: mul_a = $signed({3'b000, q_gyro_reg});
            OP_UPD_00:
            begin
                mul_a = 34'(t0_reg);
                mul_b = 34'(k0_reg);
            end
            OP_UPD_01:
            begin
                mul_a = 34'(t1_reg);
                mul_b = 34'(k0_reg);
            end
            OP_UPD_10:
            begin
                mul_a = 34'(t0_reg);
                mul_b = 34'(k1_reg);
            end
            OP_UPD_11:
            begin
                mul_a = 34'(t1_reg);
                mul_b = 34'(k1_reg);
            end
            OP_CORR_BIAS:
            begin
                mul_a = 34'(meas_reg) - 34'(angle_reg);
                mul_b = 34'(k1_reg);
            end
            OP_CORR_ANGLE:
            begin
                mul_a = 34'(meas_reg) - 34'(angle_reg);
                mul_b = 34'(k0_reg);
            end
            default: mul_a = 34'sd0;
        endcase
    end

    assign mul_start = (state_reg == S_MUL);
    assign div_start = (state_reg == S_DIV) && e_pos;
    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign angle_est = angle_out_reg;
    assign rate_est = rate_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_PREDICT;
            sel_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            q_angle_reg <= QAngleReset;
            q_gyro_reg <= QGyroReset;
            r_angle_reg <= RAngleReset;
            period_reg <= PeriodReset;
            angle_reg <= 32'sd0;
            bias_reg <= 32'sd0;
            c00_reg <= CovOne;
            c01_reg <= 32'sd0;
            c10_reg <= 32'sd0;
            c11_reg <= CovOne;
            k0_reg <= 32'sd0;
            k1_reg <= 32'sd0;
            t0_reg <= 32'sd0;
            t1_reg <= 32'sd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_Q_ANGLE: q_angle_reg <= cfg_data;
                    REG_Q_GYRO: q_gyro_reg <= cfg_data;
                    REG_R_ANGLE: r_angle_reg <= cfg_data;
                    REG_PERIOD: period_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg <= OP_PREDICT;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_MWAIT;
                S_MWAIT:
                begin
                    if (mul_done)
                    begin
                        unique case (op_reg)
                            OP_PREDICT:
                                angle_reg <= sat32(45'(angle_reg) + 45'(mul_res));
                            OP_PROP_00: c00_reg <= sat32(45'(c00_reg) + 45'(mul_res));
                            OP_PROP_X1:
                            begin
                                c01_reg <= sat32(45'(c01_reg) - 45'(mul_res));
                                c10_reg <= sat32(45'(c10_reg) - 45'(mul_res));
                            end
                            OP_PROP_11: c11_reg <= sat32(45'(c11_reg) + 45'(mul_res));
                            OP_UPD_00: c00_reg <= sat32(45'(c00_reg) - 45'(mul_res));
                            OP_UPD_01: c01_reg <= sat32(45'(c01_reg) - 45'(mul_res));
                            OP_UPD_10: c10_reg <= sat32(45'(c10_reg) - 45'(mul_res));
                            OP_UPD_11: c11_reg <= sat32(45'(c11_reg) - 45'(mul_res));
                            OP_CORR_BIAS:
                                bias_reg <= sat32(45'(bias_reg) + 45'(mul_res));
                            OP_CORR_ANGLE:
                                angle_reg <= sat32(45'(angle_reg) + 45'(mul_res));
                            default: ;
                        endcase
                        if (op_reg == OP_PROP_11)
                        begin
                            sel_reg <= 1'b0;
                            state_reg <= S_DIV;
                        end
                        else if (op_reg == OP_CORR_ANGLE)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            op_reg <= op_reg + 4'd1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_DIV:
                begin
                    if (e_pos)
                    begin
                        state_reg <= S_DWAIT;
                    end
                    else
                    begin
                        k0_reg <= 32'sd0;
                        k1_reg <= 32'sd0;
                        t0_reg <= c00_reg;
                        t1_reg <= c01_reg;
                        op_reg <= OP_UPD_00;
                        state_reg <= S_MUL;
                    end
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        if (!sel_reg)
                        begin
                            k0_reg <= div_quot;
                            sel_reg <= 1'b1;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            k1_reg <= div_quot;
                            t0_reg <= c00_reg;
                            t1_reg <= c01_reg;
                            op_reg <= OP_UPD_00;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            meas_reg <= angle_meas;
            gyro_reg <= gyro_rate;
        end
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            angle_out_reg <= angle_reg;
            rate_out_reg <= sat32(45'(gyro_reg) - 45'(bias_reg));
        end
    end

    `ABKF_ASSERT_SAME(a_accept_idle, in_valid && in_ready, state_reg == S_IDLE)
    `ABKF_ASSERT_SAME(a_mul_done_wait, mul_done, state_reg == S_MWAIT)
    `ABKF_ASSERT_SAME(a_div_done_wait, div_done, state_reg == S_DWAIT)
    `ABKF_ASSERT_NEXT(a_out_load, state_reg == S_OUT && !out_valid_reg, out_valid_reg)

endmodule

// ----- rtl/core/abkf_mul.sv -----
// Bit-serial signed multiplier with rounding of the product by 2^24.
// Depends on abkf_pkg.
module abkf_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [33:0]  a,
    input  logic signed [33:0]  b,
    output logic                done,
    output logic signed [43:0]  result
);
    import abkf_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] hi_reg, hi_next;
    logic [32:0] lo_reg, lo_next;
    logic [32:0] mcand_reg, mcand_next;
    logic        neg_reg, neg_next;
    logic [33:0] a_mag, b_mag, sum;
    logic [66:0] rsum;
    logic [43:0] mag;

    always_comb
    begin
        a_mag = a[33] ? 34'(-a) : 34'(a);
        b_mag = b[33] ? 34'(-b) : 34'(b);
        sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : 34'd0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        mcand_next = mcand_reg;
        neg_next = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            hi_next = 33'd0;
            lo_next = b_mag[32:0];
            mcand_next = a_mag[32:0];
            neg_next = a[33] ^ b[33];
        end
        else if (busy_reg)
        begin
            hi_next = sum[33:1];
            lo_next = {sum[0], lo_reg[32:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd32)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        mcand_reg <= mcand_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        rsum = {1'b0, hi_reg, lo_reg} + (67'd1 << (FracBits - 1));
        mag = {2'b00, rsum[65:24]};
        result = neg_reg ? -$signed(mag) : $signed(mag);
    end

    assign done = done_reg;

endmodule

// ----- rtl/core/abkf_div.sv -----
// Restoring divider, one quotient bit per cycle, giving sat(num * 2^24 / den).
// Depends on abkf_pkg.
module abkf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic [32:0]        den,
    output logic               done,
    output logic signed [31:0] quot
);
    import abkf_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [55:0] nsh_reg, nsh_next;
    logic [55:0] q_reg, q_next;
    logic [32:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [31:0] num_mag;
    logic [33:0] trial;
    logic [33:0] diff;

    always_comb
    begin
        num_mag = num[31] ? 32'(-num) : 32'(num);
        trial = {rem_reg, nsh_reg[55]};
        diff = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        nsh_next = nsh_reg;
        q_next = q_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            rem_next = 33'd0;
            nsh_next = {num_mag, 24'd0};
            q_next = 56'd0;
            den_next = den;
            neg_next = num[31];
        end
        else if (busy_reg)
        begin
            nsh_next = {nsh_reg[54:0], 1'b0};
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                q_next = {q_reg[54:0], 1'b1};
            end
            else
            begin
                rem_next = trial[32:0];
                q_next = {q_reg[54:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd55)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        nsh_reg <= nsh_next;
        q_reg <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (neg_reg)
        begin
            quot = (q_reg > 56'd2147483648) ? 32'sh80000000 : -$signed(q_reg[31:0]);
        end
        else
        begin
            quot = (q_reg > 56'd2147483647) ? 32'sh7fffffff : $signed(q_reg[31:0]);
        end
    end

    assign done = done_reg;

endmodule

// ----- sim/angle_bias_kalman_filter_core_test.sv -----
// Self-checking testbench for angle_bias_kalman_filter_core.
// Depends on abkf_pkg and the RTL only. It checks every result against an
// internal predictor of the filter, or a typed table row against its listed value, over several register settings.
module angle_bias_kalman_filter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import abkf_pkg::*;

    localparam logic [2:0] RegUnused = 3'd6;
    localparam int StallLimit = 20000;
    localparam int DrainCycles = 600;
    localparam int PhaseItems = 150;
    localparam int RandomItems = 880;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
        bit                 typed;
        logic signed [31:0] angle_exp;
        logic signed [31:0] rate_exp;
    } sample_row_t;

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } fused_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] angle_meas;
    logic signed [31:0] gyro_rate;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] angle_est;
    logic signed [31:0] rate_est;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [30:0]        cfg_data;

    fused_t fused_queue[$];
    longint q_angle_m, q_gyro_m, r_angle_m, period_m;
    longint angle_m, bias_m, p00_m, p01_m, p10_m, p11_m;
    int     errors;
    int     samples_sent;
    int     results_seen;
    int     idle_cycles;
    bit     steady;

    angle_bias_kalman_filter_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .angle_meas (angle_meas),
        .gyro_rate  (gyro_rate),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .angle_est  (angle_est),
        .rate_est   (rate_est),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint round_q24(longint x);
        logic [63:0] m;
        m = (x < 0) ? 64'(-x) : 64'(x);
        m = (m + 64'd8388608) >> FracBits;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    task automatic reset_filter_model();
        q_angle_m = QAngleReset;
        q_gyro_m = QGyroReset;
        r_angle_m = RAngleReset;
        period_m = PeriodReset;
        angle_m = 0;
        bias_m = 0;
        p00_m = CovOne;
        p01_m = 0;
        p10_m = 0;
        p11_m = CovOne;
    endtask

    task automatic apply_register(logic [2:0] idx, logic [30:0] value);
        case (idx)
            REG_Q_ANGLE: q_angle_m = value;
            REG_Q_GYRO: q_gyro_m = value;
            REG_R_ANGLE: r_angle_m = value;
            REG_PERIOD: period_m = value;
            default: ;
        endcase
    endtask

    task automatic filter_step(logic signed [31:0] meas, logic signed [31:0] gyro,
                               output fused_t res);
        longint g, p11_old, pd, err, e, k0, k1, t0, t1;
        g = gyro;
        p11_old = p11_m;
        angle_m = clamp32(angle_m + round_q24((g - bias_m) * period_m));
        pd = clamp32(q_angle_m - p01_m - p10_m);
        p00_m = clamp32(p00_m + round_q24(pd * period_m));
        p01_m = clamp32(p01_m - round_q24(p11_old * period_m));
        p10_m = clamp32(p10_m - round_q24(p11_old * period_m));
        p11_m = clamp32(p11_old + round_q24(q_gyro_m * period_m));
        err = longint'(meas) - angle_m;
        e = r_angle_m + p00_m;
        k0 = 0;
        k1 = 0;
        if (e > 0)
        begin
            k0 = clamp32((p00_m <<< FracBits) / e);
            k1 = clamp32((p10_m <<< FracBits) / e);
        end
        t0 = p00_m;
        t1 = p01_m;
        p00_m = clamp32(p00_m - round_q24(k0 * t0));
        p01_m = clamp32(p01_m - round_q24(k0 * t1));
        p10_m = clamp32(p10_m - round_q24(k1 * t0));
        p11_m = clamp32(p11_m - round_q24(k1 * t1));
        angle_m = clamp32(angle_m + round_q24(k0 * err));
        bias_m = clamp32(bias_m + round_q24(k1 * err));
        res.angle = 32'(angle_m);
        res.rate = 32'(clamp32(g - bias_m));
    endtask

    task automatic write_register(logic [2:0] idx, logic [30:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        apply_register(idx, value);
    endtask

    task automatic write_all(logic [30:0] qa, logic [30:0] qg, logic [30:0] ra,
                             logic [30:0] per);
        write_register(REG_Q_ANGLE, qa);
        write_register(REG_Q_GYRO, qg);
        write_register(REG_R_ANGLE, ra);
        write_register(REG_PERIOD, per);
        write_register(RegUnused, 31'h7fffffff);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (fused_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic send_sample(logic signed [31:0] meas, logic signed [31:0] gyro,
                               bit typed, fused_t typed_res);
        fused_t res;
        if (!steady && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        angle_meas <= meas;
        gyro_rate <= gyro;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        filter_step(meas, gyro, res);
        fused_queue.push_back(typed ? typed_res : res);
        samples_sent++;
    endtask

    function automatic logic signed [31:0] random_field();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(200 << 16)) - (100 << 16);
            default: return $signed($urandom_range(2000 << 16)) - (1000 << 16);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        fused_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (fused_queue.size() == 0)
            begin
                $display("%0t: unexpected result angle_est=%0d rate_est=%0d",
                         $time, angle_est, rate_est);
                errors++;
            end
            else
            begin
                want = fused_queue.pop_front();
                if (angle_est !== want.angle)
                begin
                    $display("%0t: angle_est expected %0d actual %0d",
                             $time, want.angle, angle_est);
                    errors++;
                end
                if (rate_est !== want.rate)
                begin
                    $display("%0t: rate_est expected %0d actual %0d",
                             $time, want.rate, rate_est);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= StallLimit)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, StallLimit);
            $display("angle_bias_kalman_filter_core_test: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        sample_row_t rows[$];
        fused_t typed_res;
        int settings;
        rst_n = 1'b0;
        in_valid = 1'b0;
        angle_meas = '0;
        gyro_rate = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        samples_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        steady = 1'b0;
        settings = 1;
        reset_filter_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0},
            '{32'sh7fffffff, 32'sd0, 1'b0, 32'sd0, 32'sd0},
            '{32'sh80000000, 32'sd0, 1'b0, 32'sd0, 32'sd0},
            '{32'sd0, 32'sh7fffffff, 1'b0, 32'sd0, 32'sd0},
            '{32'sd0, 32'sh80000000, 1'b0, 32'sd0, 32'sd0},
            '{32'sh7fffffff, 32'sh7fffffff, 1'b0, 32'sd0, 32'sd0},
            '{32'sh80000000, 32'sh80000000, 1'b0, 32'sd0, 32'sd0},
            '{32'sh7fffffff, 32'sh80000000, 1'b0, 32'sd0, 32'sd0},
            '{32'sh80000000, 32'sh7fffffff, 1'b0, 32'sd0, 32'sd0},
            '{-32'sd1, 32'sd1, 1'b0, 32'sd0, 32'sd0},
            '{32'sd1, -32'sd1, 1'b0, 32'sd0, 32'sd0},
            '{32'sd5898240, 32'sd0, 1'b0, 32'sd0, 32'sd0},
            '{-32'sd5898240, 32'sd655360, 1'b0, 32'sd0, 32'sd0},
            '{32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0}
        };
        foreach (rows[i])
        begin
            typed_res.angle = rows[i].angle_exp;
            typed_res.rate = rows[i].rate_exp;
            send_sample(rows[i].angle, rows[i].rate, rows[i].typed, typed_res);
        end

        // Largest tuning values, then zero noise and a zero time step, where
        // the innovation variance can fall to zero and the gains vanish.
        wait_idle();
        write_all(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        settings++;
        for (int i = 0; i < 6; i++)
        begin
            send_sample($urandom, $urandom, 1'b0, typed_res);
        end
        wait_idle();
        write_all(31'd0, 31'd0, 31'd0, 31'd0);
        settings++;
        for (int i = 0; i < 6; i++)
        begin
            send_sample($urandom, $urandom, 1'b0, typed_res);
        end

        for (int i = 0; i < RandomItems; i++)
        begin
            if (i % PhaseItems == 0)
            begin
                wait_idle();
                case ((i / PhaseItems) % 3)
                    0: write_all(QAngleReset, QGyroReset, RAngleReset, PeriodReset);
                    1: write_all(31'($urandom_range(1 << 24)),
                                 31'($urandom_range(1 << 24)),
                                 31'($urandom_range(1 << 25, 1)),
                                 31'($urandom_range(1 << 22, 1)));
                    default: write_all(31'($urandom), 31'($urandom), 31'($urandom),
                                       31'($urandom));
                endcase
                settings++;
            end
            steady = (i >= 300 && i < 450);
            send_sample(random_field(), random_field(), 1'b0, typed_res);
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        while (fused_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        $display("Sent %0d samples and checked %0d results over %0d register settings,",
                 samples_sent, results_seen, settings);
        $display("with random gaps on both channels and a stretch without any.");
        if (errors == 0 && fused_queue.size() == 0)
        begin
            $display("angle_bias_kalman_filter_core_test: PASS");
        end
        else
        begin
            $display("angle_bias_kalman_filter_core_test: FAIL");
        end
        $finish;
    end

endmodule
